// File: hw/rtl/tpc_pkg.sv
package tpc_pkg;

  localparam int COORD_BITS = 20;
  localparam int WORD_BITS  = 60;
  localparam int TFRAC_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
  localparam int DIST_BITS  = PROD_BITS + 2;
  localparam int DEN_BITS   = DIST_BITS + 1;
  localparam int NUM_BITS   = DEN_BITS + TFRAC_BITS;
  localparam int T_BITS     = TFRAC_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] lane_t;
  typedef logic signed [DIST_BITS-1:0]  dist_t;
  typedef logic [T_BITS-1:0]            t_frac_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] p;
    logic [WORD_BITS-1:0] n;
    logic [WORD_BITS-1:0] w;
  } vtx_t;

  // lane k of a packed word, missing high bits read as zero
  function automatic lane_t lane_get(input logic [WORD_BITS-1:0] word, input int k);
    logic [3*COORD_BITS-1:0] ext;
    ext = (3*COORD_BITS)'(word);
    return lane_t'(ext[k*COORD_BITS +: COORD_BITS]);
  endfunction

  function automatic logic [WORD_BITS-1:0] lane_pack(input lane_t x, input lane_t y,
                                                     input lane_t z);
    logic [3*COORD_BITS-1:0] r;
    r = {z, y, x};
    return WORD_BITS'(r);
  endfunction

endpackage

// File: hw/rtl/tpc_divider.sv
// pipelined restoring divider, one quotient bit per stage
module tpc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [tpc_pkg::NUM_BITS-1:0]     num,
  input  logic [tpc_pkg::DEN_BITS-1:0]     den,
  output logic                             out_valid,
  output tpc_pkg::t_frac_t                 quo
);
  localparam int STEPS = tpc_pkg::T_BITS;
  localparam int RBITS = tpc_pkg::DEN_BITS + 1;

  logic [STEPS:0]                     v;
  logic [STEPS:0][RBITS-1:0]          rem;
  logic [STEPS:0][tpc_pkg::NUM_BITS-1:0] nm;
  logic [STEPS:0][tpc_pkg::DEN_BITS-1:0] dn;
  logic [STEPS:0][STEPS-1:0]          q;

  // quotient fits in T_BITS since num <= 2^16*den + den/2
  assign v[0]   = in_valid;
  assign rem[0] = RBITS'(num >> STEPS);
  assign nm[0]  = num;
  assign dn[0]  = den;
  assign q[0]   = '0;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RBITS-1:0] sh;
    logic             ge;
    assign sh = {rem[s][RBITS-2:0], nm[s][STEPS-1-s]};
    assign ge = sh >= RBITS'(dn[s]);
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else v[s+1] <= v[s];
      rem[s+1] <= ge ? sh - RBITS'(dn[s]) : sh;
      nm[s+1]  <= nm[s];
      dn[s+1]  <= dn[s];
      q[s+1]   <= {q[s][STEPS-2:0], ge};
    end
  end

  assign out_valid = v[STEPS];
  assign quo       = q[STEPS];
endmodule

// File: hw/rtl/tpc_lerp.sv
// one packed vector interpolated from i towards o, two stages
module tpc_lerp (
  input  logic                          clk,
  input  logic [tpc_pkg::WORD_BITS-1:0] vi,
  input  logic [tpc_pkg::WORD_BITS-1:0] vo,
  input  tpc_pkg::t_frac_t              t,
  output logic [tpc_pkg::WORD_BITS-1:0] res
);
  localparam int PB = tpc_pkg::MAG_BITS + tpc_pkg::T_BITS;

  tpc_pkg::lane_t              a_q [3];
  logic [2:0]                  neg_q;
  logic [PB-1:0]               prod_q [3];
  tpc_pkg::lane_t              r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [tpc_pkg::MAG_BITS-1:0] d;
      logic [tpc_pkg::MAG_BITS-1:0]        m;
      d = tpc_pkg::MAG_BITS'(tpc_pkg::lane_get(vo, k))
        - tpc_pkg::MAG_BITS'(tpc_pkg::lane_get(vi, k));
      m = d[tpc_pkg::MAG_BITS-1] ? -d : d;
      a_q[k]    <= tpc_pkg::lane_get(vi, k);
      neg_q[k]  <= d[tpc_pkg::MAG_BITS-1];
      prod_q[k] <= PB'(m) * PB'(t);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [PB-1:0] rr;
      rr = (prod_q[k] + PB'(1 << (tpc_pkg::TFRAC_BITS - 1))) >> tpc_pkg::TFRAC_BITS;
      r[k] = neg_q[k] ? a_q[k] - tpc_pkg::COORD_BITS'(rr) : a_q[k] + tpc_pkg::COORD_BITS'(rr);
    end
  end

  always_ff @(posedge clk) res <= tpc_pkg::lane_pack(r[0], r[1], r[2]);
endmodule

// File: hw/rtl/triangle_plane_clipper.sv
// Triangle clipper against one plane. A triangle is taken on a cycle where
// start is high and busy is low; each vertex is classified by its signed
// distance to the plane (zero counts as inside), and 0, 1 or 2 triangles come
// out on done, one per cycle, with last_of_run on the final one. The path is a
// fixed pipeline: distance (2 stages), edge setup feeding a 17-stage divider
// for t, a 2-stage interpolator and an output register; the second beat of a
// two-result triangle comes out in the cycle after the first. The receiver
// cannot stall. A triangle that yields two results holds the input off (busy,
// while it sits in the distance stage); a triangle already accepted right
// behind it waits in the first stage meanwhile. The sustained rate is one
// triangle per cycle for 0/1 results; a two-result triangle holds the input
// off as above. The user must write configuration only while the pipeline
// is empty; the block itself does not enforce it.
module triangle_plane_clipper (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [59:0] cfg_data,
  input  logic [59:0] pos_a, pos_b, pos_c,
  input  logic [59:0] norm_a, norm_b, norm_c,
  input  logic [59:0] world_a, world_b, world_c,
  output logic        done,
  output logic [59:0] out_pos_a, out_pos_b, out_pos_c,
  output logic [59:0] out_norm_a, out_norm_b, out_norm_c,
  output logic [59:0] out_world_a, out_world_b, out_world_c,
  output logic        last_of_run
);
  localparam int W  = tpc_pkg::WORD_BITS;
  localparam int DB = tpc_pkg::DIST_BITS;
  localparam int DLAT = tpc_pkg::T_BITS;  // divider stages
  localparam int ALIGN = DLAT + 2;        // edge setup to lerp output

  logic [W-1:0] plane_point, plane_normal;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_point  <= '0;
      plane_normal <= W'(64'd1 << (2 * tpc_pkg::COORD_BITS + 12));
    end else if (cfg_we) begin
      if (cfg_index) plane_normal <= cfg_data;
      else plane_point <= cfg_data;
    end
  end

  // second beat of a two-result triangle blocks the input while hold is up
  logic accept;
  logic hold;
  assign accept = start && !busy;

  // stage 1: lane products; holds its beat while hold is up
  tpc_pkg::vtx_t v1 [3];
  logic          s1_v;
  logic signed [tpc_pkg::PROD_BITS-1:0] prod1 [3][3];
  logic [W-1:0] pin [3];
  assign pin[0] = pos_a;
  assign pin[1] = pos_b;
  assign pin[2] = pos_c;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (!hold) s1_v <= accept;
    if (!hold) begin
      v1[0] <= '{pos_a, norm_a, world_a};
      v1[1] <= '{pos_b, norm_b, world_b};
      v1[2] <= '{pos_c, norm_c, world_c};
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          logic signed [tpc_pkg::DIFF_BITS-1:0] df;
          df = tpc_pkg::DIFF_BITS'(tpc_pkg::lane_get(pin[i], k))
             - tpc_pkg::DIFF_BITS'(tpc_pkg::lane_get(plane_point, k));
          prod1[i][k] <= tpc_pkg::PROD_BITS'(df)
                       * tpc_pkg::PROD_BITS'(tpc_pkg::lane_get(plane_normal, k));
        end
      end
    end
  end

  // stage 2: distances and classification; a bubble enters while hold is up
  tpc_pkg::vtx_t v2 [3];
  tpc_pkg::dist_t d2 [3];
  logic           s2_v;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v && !hold;
    v2 <= v1;
    for (int i = 0; i < 3; i++)
      d2[i] <= DB'(prod1[i][0]) + DB'(prod1[i][1]) + DB'(prod1[i][2]);
  end

  // stage 3: case select, edge pairs and divider operands
  logic [2:0] ins2;
  logic [1:0] nin2;
  always_comb begin
    for (int i = 0; i < 3; i++) ins2[i] = !d2[i][DB-1];
    nin2 = 2'(ins2[0]) + 2'(ins2[1]) + 2'(ins2[2]);
  end

  logic [1:0] ia, ib, oa, ob;  // edges: ia->oa, ib->ob
  always_comb begin
    ia = 2'd0; ib = 2'd0; oa = 2'd0; ob = 2'd0;
    case (ins2)
      3'b001: begin ia = 2'd0; ib = 2'd0; oa = 2'd1; ob = 2'd2; end
      3'b010: begin ia = 2'd1; ib = 2'd1; oa = 2'd0; ob = 2'd2; end
      3'b100: begin ia = 2'd2; ib = 2'd2; oa = 2'd0; ob = 2'd1; end
      3'b011: begin ia = 2'd0; ib = 2'd1; oa = 2'd2; ob = 2'd2; end
      3'b101: begin ia = 2'd0; ib = 2'd2; oa = 2'd1; ob = 2'd1; end
      3'b110: begin ia = 2'd1; ib = 2'd2; oa = 2'd0; ob = 2'd0; end
      default: ;
    endcase
  end

  logic [tpc_pkg::DEN_BITS-1:0] den_a, den_b;
  logic [tpc_pkg::NUM_BITS-1:0] num_a, num_b;
  always_comb begin
    den_a = tpc_pkg::DEN_BITS'(d2[ia]) - tpc_pkg::DEN_BITS'(d2[oa]);
    den_b = tpc_pkg::DEN_BITS'(d2[ib]) - tpc_pkg::DEN_BITS'(d2[ob]);
    num_a = (tpc_pkg::NUM_BITS'(d2[ia]) << tpc_pkg::TFRAC_BITS)
          + tpc_pkg::NUM_BITS'(den_a >> 1);
    num_b = (tpc_pkg::NUM_BITS'(d2[ib]) << tpc_pkg::TFRAC_BITS)
          + tpc_pkg::NUM_BITS'(den_b >> 1);
  end

  typedef struct packed {
    logic [1:0]     nin;
    logic [1:0]     ia, ib, oa, ob;
    tpc_pkg::vtx_t  v0, v1, v2;
  } ctl_t;

  ctl_t ctl2;
  assign ctl2 = '{nin2, ia, ib, oa, ob, v2[0], v2[1], v2[2]};

  // control travels beside the divider
  logic [ALIGN:0] cv;
  ctl_t           cd [ALIGN+1];
  assign cv[0] = s2_v && (nin2 != 2'd0);
  assign cd[0] = ctl2;
  for (genvar s = 0; s < ALIGN; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) cv[s+1] <= 1'b0;
      else cv[s+1] <= cv[s];
      cd[s+1] <= cd[s];
    end
  end

  logic qv_a, qv_b;
  tpc_pkg::t_frac_t t_a, t_b;
  tpc_divider u_div_a (.clk, .rst, .in_valid(cv[0]), .num(num_a), .den(den_a),
                       .out_valid(qv_a), .quo(t_a));
  tpc_divider u_div_b (.clk, .rst, .in_valid(cv[0]), .num(num_b), .den(den_b),
                       .out_valid(qv_b), .quo(t_b));

  ctl_t cq;
  assign cq = cd[DLAT];
  tpc_pkg::vtx_t vs [3];
  assign vs[0] = cq.v0;
  assign vs[1] = cq.v1;
  assign vs[2] = cq.v2;

  tpc_pkg::vtx_t ea, eb;
  tpc_lerp u_lp_a (.clk, .vi(vs[cq.ia].p), .vo(vs[cq.oa].p), .t(t_a), .res(ea.p));
  tpc_lerp u_ln_a (.clk, .vi(vs[cq.ia].n), .vo(vs[cq.oa].n), .t(t_a), .res(ea.n));
  tpc_lerp u_lw_a (.clk, .vi(vs[cq.ia].w), .vo(vs[cq.oa].w), .t(t_a), .res(ea.w));
  tpc_lerp u_lp_b (.clk, .vi(vs[cq.ib].p), .vo(vs[cq.ob].p), .t(t_b), .res(eb.p));
  tpc_lerp u_ln_b (.clk, .vi(vs[cq.ib].n), .vo(vs[cq.ob].n), .t(t_b), .res(eb.n));
  tpc_lerp u_lw_b (.clk, .vi(vs[cq.ib].w), .vo(vs[cq.ob].w), .t(t_b), .res(eb.w));

  // output stage; second beat of a two-result triangle taken next cycle
  ctl_t          cf;
  tpc_pkg::vtx_t ws [3];
  tpc_pkg::vtx_t sa, sb, sc;
  tpc_pkg::vtx_t h_e1, h_i2, h_e2;
  logic          fv;
  assign cf = cd[ALIGN];
  assign fv = cv[ALIGN];
  assign ws[0] = cf.v0;
  assign ws[1] = cf.v1;
  assign ws[2] = cf.v2;

  always_comb begin
    sa = ws[0]; sb = ws[1]; sc = ws[2];
    case (cf.nin)
      2'd1: begin sa = ws[cf.ia]; sb = ea; sc = eb; end
      2'd2: begin sa = ea; sb = ws[cf.ia]; sc = ws[cf.ib]; end
      default: ;
    endcase
  end

  // busy predicts a hold slot: a two-inside triangle in stage 2 blocks
  // the input and stage 1 keeps its beat, so the extra beat finds a free slot
  assign hold = s2_v && (nin2 == 2'd2);
  assign busy = hold;

  logic second;
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      second <= 1'b0;
    end else begin
      second <= fv && (cf.nin == 2'd2);
      done   <= fv || second;
    end
    h_e1 <= ea;
    h_i2 <= ws[cf.ib];
    h_e2 <= eb;
    if (second) begin
      {out_pos_a, out_norm_a, out_world_a} <= {h_e1.p, h_e1.n, h_e1.w};
      {out_pos_b, out_norm_b, out_world_b} <= {h_i2.p, h_i2.n, h_i2.w};
      {out_pos_c, out_norm_c, out_world_c} <= {h_e2.p, h_e2.n, h_e2.w};
      last_of_run <= 1'b1;
    end else begin
      {out_pos_a, out_norm_a, out_world_a} <= {sa.p, sa.n, sa.w};
      {out_pos_b, out_norm_b, out_world_b} <= {sb.p, sb.n, sb.w};
      {out_pos_c, out_norm_c, out_world_c} <= {sc.p, sc.n, sc.w};
      last_of_run <= cf.nin != 2'd2;
    end
  end

  a_div_align: assert property (@(posedge clk) disable iff (rst) qv_a == cv[DLAT])
    else $error("divider out of step with control");
  a_div_pair: assert property (@(posedge clk) disable iff (rst) qv_a == qv_b)
    else $error("dividers out of step");
  a_second: assert property (@(posedge clk) disable iff (rst) second |-> done)
    else $error("second beat lost");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) second |-> !fv)
    else $error("second beat collides with new result");
endmodule

// File: tb/tb_clip_pkg.sv
package tb_clip_pkg;

  // configuration register indexes
  localparam logic REG_PLANE_POINT  = 1'b0;
  localparam logic REG_PLANE_NORMAL = 1'b1;

  // reset value of the plane normal: z lane = 4096, x and y lanes zero
  localparam logic [59:0] NORMAL_RESET = 60'h010_0000_0000_0000;

endpackage

// File: tb/tb_clip_checker.sv
module tb_clip_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [59:0]      cfg_data,
  input  logic [8:0][59:0] tri_words,
  input  logic             done,
  input  logic [8:0][59:0] res_words,
  input  logic             last_of_run,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [8:0][59:0] words;
    logic             last;
  } clip_beat_t;

  // one vertex: pos x,y,z then normal x,y,z then world x,y,z
  typedef longint vert_t [9];

  clip_beat_t  tri_queue[$];
  logic [59:0] plane_pt, plane_nrm;

  function automatic longint lane_of(logic [59:0] word, int k);
    tpc_pkg::lane_t x;
    x = word[k*tpc_pkg::COORD_BITS +: tpc_pkg::COORD_BITS];
    return longint'(x);
  endfunction

  function automatic longint plane_dist(logic [59:0] p);
    longint d;
    d = 0;
    for (int k = 0; k < 3; k++)
      d += (lane_of(p, k) - lane_of(plane_pt, k)) * lane_of(plane_nrm, k);
    return d;
  endfunction

  function automatic void edge_vert(input vert_t vi, input longint di, input vert_t vo,
                                    input longint dout, output vert_t r);
    longint unsigned den, t, mag, step;
    longint delta;
    den = longint'(di - dout);
    t = ((longint'(di) << tpc_pkg::TFRAC_BITS) + den / 2) / den;
    for (int i = 0; i < 9; i++) begin
      delta = vo[i] - vi[i];
      mag = delta < 0 ? -delta : delta;
      step = (mag * t + (64'd1 << (tpc_pkg::TFRAC_BITS - 1))) >> tpc_pkg::TFRAC_BITS;
      r[i] = delta < 0 ? vi[i] - longint'(step) : vi[i] + longint'(step);
    end
  endfunction

  function automatic logic [59:0] pack_field(vert_t v, int f);
    logic [59:0] r;
    r = '0;
    for (int k = 0; k < 3; k++)
      r[k*tpc_pkg::COORD_BITS +: tpc_pkg::COORD_BITS] = v[f*3+k][tpc_pkg::COORD_BITS-1:0];
    return r;
  endfunction

  function automatic void push_tri(vert_t a, vert_t b, vert_t c, logic last);
    clip_beat_t e;
    for (int f = 0; f < 3; f++) begin
      e.words[f*3]   = pack_field(a, f);
      e.words[f*3+1] = pack_field(b, f);
      e.words[f*3+2] = pack_field(c, f);
    end
    e.last = last;
    tri_queue.insert(tri_queue.size(), e);
  endfunction

  function automatic void predict_clip(logic [8:0][59:0] w);
    vert_t  v[3];
    vert_t  e1, e2;
    longint d[3];
    int     ins[3], outs[3];
    int     nin, nout;
    nin  = 0;
    nout = 0;
    for (int i = 0; i < 3; i++) begin
      for (int f = 0; f < 3; f++)
        for (int k = 0; k < 3; k++)
          v[i][f*3+k] = lane_of(w[f*3+i], k);
      d[i] = plane_dist(w[i]);
      if (d[i] >= 0) begin
        ins[nin] = i;
        nin++;
      end else begin
        outs[nout] = i;
        nout++;
      end
    end
    case (nin)
      3: push_tri(v[0], v[1], v[2], 1'b1);
      1: begin
        edge_vert(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], e1);
        edge_vert(v[ins[0]], d[ins[0]], v[outs[1]], d[outs[1]], e2);
        push_tri(v[ins[0]], e1, e2, 1'b1);
      end
      2: begin
        edge_vert(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], e1);
        edge_vert(v[ins[1]], d[ins[1]], v[outs[0]], d[outs[0]], e2);
        push_tri(e1, v[ins[0]], v[ins[1]], 1'b0);
        push_tri(e1, v[ins[1]], e2, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    clip_beat_t exp_tri;
    logic       bad;
    if (rst) begin
      plane_pt  <= '0;
      plane_nrm <= tb_clip_pkg::NORMAL_RESET;
      errors    <= 0;
      pending   <= 0;
      tri_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == tb_clip_pkg::REG_PLANE_POINT) plane_pt <= cfg_data;
        else plane_nrm <= cfg_data;
      end
      if (start && !busy) predict_clip(tri_words);
      if (done) begin
        if (tri_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          exp_tri = tri_queue.pop_front();
          bad = (exp_tri.words != res_words) || (exp_tri.last != last_of_run);
          if (bad) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("mismatch at %0t", $realtime);
              for (int i = 0; i < 9; i++)
                $display("  word %0d exp %h got %h", i, exp_tri.words[i], res_words[i]);
              $display("  last exp %b got %b", exp_tri.last, last_of_run);
            end
          end
        end
      end
      pending <= tri_queue.size();
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top;

  localparam int DRAIN_CYCLES = 40;   // drain wait, longer than the pipeline
  localparam int IDLE_LIMIT   = 4000;

  logic             clk, rst, start, busy, cfg_we, cfg_index, done, last_of_run;
  logic [59:0]      cfg_data;
  logic [8:0][59:0] tri_words;   // pos a..c, norm a..c, world a..c
  logic [8:0][59:0] res_words;
  int               errors, pending, idle_cycles;

  triangle_plane_clipper i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pos_a(tri_words[0]), .pos_b(tri_words[1]), .pos_c(tri_words[2]),
    .norm_a(tri_words[3]), .norm_b(tri_words[4]), .norm_c(tri_words[5]),
    .world_a(tri_words[6]), .world_b(tri_words[7]), .world_c(tri_words[8]),
    .done(done),
    .out_pos_a(res_words[0]), .out_pos_b(res_words[1]), .out_pos_c(res_words[2]),
    .out_norm_a(res_words[3]), .out_norm_b(res_words[4]), .out_norm_c(res_words[5]),
    .out_world_a(res_words[6]), .out_world_b(res_words[7]), .out_world_c(res_words[8]),
    .last_of_run(last_of_run)
  );

  // checker sits beside the block, predicting from what it sees on the ports
  tb_clip_checker i_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tri_words(tri_words), .done(done), .res_words(res_words),
    .last_of_run(last_of_run), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: too long without an accepted triangle or a result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [59:0] rnd_word();
    return 60'({$urandom, $urandom});
  endfunction

  // three lanes of 20 bits, z in the top lane
  function automatic logic [59:0] vec(logic [19:0] x, logic [19:0] y, logic [19:0] z);
    return {z, y, x};
  endfunction

  // small lanes keep most triangles near the plane so clipping actually happens
  function automatic logic [59:0] near_word(int span);
    logic [59:0] r;
    for (int k = 0; k < 3; k++)
      r[k*20 +: 20] = 20'($signed($urandom_range(0, 2*span)) - span);
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // one triangle beat; start stays high across back to back beats
  task automatic send_tri(logic [8:0][59:0] w);
    int gap;
    tri_words <= w;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain, then rewrite both plane registers while the pipe is empty
  task automatic set_plane(logic [59:0] pt, logic [59:0] nrm);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tb_clip_pkg::REG_PLANE_POINT;
    cfg_data  <= pt;
    @(posedge clk);
    cfg_index <= tb_clip_pkg::REG_PLANE_NORMAL;
    cfg_data  <= nrm;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // triangle with given z per vertex, random x/y, random normals and world
  task automatic send_z(logic [19:0] za, logic [19:0] zb, logic [19:0] zc);
    logic [8:0][59:0] w;
    for (int i = 0; i < 9; i++) w[i] = near_word(20000);
    w[0][59:40] = za;
    w[1][59:40] = zb;
    w[2][59:40] = zc;
    send_tri(w);
  endtask

  task automatic random_phase(int count, int span);
    logic [8:0][59:0] w;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++)
        w[i] = ($urandom_range(0, 9) < 7) ? near_word(span) : rnd_word();
      send_tri(w);
    end
  endtask

  initial begin
    logic [8:0][59:0] w;
    rst       <= 1'b1;
    start     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= tb_clip_pkg::REG_PLANE_POINT;
    cfg_data  <= '0;
    tri_words <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset plane z >= 0: every in/out mix, on-plane vertex
    send_z(20'h00100, 20'h00200, 20'h00300);   // all inside
    send_z(20'hFFF00, 20'hFFE00, 20'hFFD00);   // all outside
    send_z(20'h00100, 20'hFFE00, 20'hFFD00);   // one inside, a
    send_z(20'hFFF00, 20'h00200, 20'hFFD00);   // one inside, b
    send_z(20'hFFF00, 20'hFFE00, 20'h00300);   // one inside, c
    send_z(20'h00100, 20'h00200, 20'hFFD00);   // two inside, c out
    send_z(20'h00100, 20'hFFE00, 20'h00300);   // two inside, b out
    send_z(20'hFFF00, 20'h00200, 20'h00300);   // two inside, a out
    send_z(20'h00000, 20'hFFFFF, 20'hFFFFF);   // on the plane counts inside
    send_z(20'h7FFFF, 20'h80000, 20'h80000);   // extreme lanes
    send_z(20'h7FFFF, 20'h7FFFF, 20'h80000);
    for (int i = 0; i < 9; i++) w[i] = vec(20'h7FFFF, 20'h80000, 20'h7FFFF);
    w[1] = vec(20'h80000, 20'h7FFFF, 20'h80000);
    send_tri(w);
    send_tri('0);
    send_tri('1);

    // zero normal: everything on the plane, passes through
    set_plane(rnd_word(), '0);
    send_tri('1);
    random_phase(4, 500000);

    // extreme plane values, both signs
    set_plane(vec(20'h80000, 20'h80000, 20'h80000), vec(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    random_phase(60, 500000);
    set_plane(vec(20'h7FFFF, 20'h7FFFF, 20'h7FFFF), vec(20'h80000, 20'h80000, 20'h80000));
    random_phase(60, 500000);

    // random planes with well-spread triangles
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) set_plane(near_word(30000), near_word(5000));
      else set_plane(rnd_word(), rnd_word());
      random_phase(240, (ph < 3) ? 30000 : 400000);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_divider.sv
hw/rtl/tpc_lerp.sv
hw/rtl/triangle_plane_clipper.sv
tb/tb_clip_pkg.sv
tb/tb_clip_checker.sv
tb/tb_top.sv
